// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the vector gcd normalize checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that is checked through reset as well.
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/vgn_pkg.sv
// ----------------------------------------------------------------------------
// Vector gcd normalize package
// Sequencer state encoding used by the vector gcd normalize design.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package vgn_pkg;

  // One-hot sequencer states.
  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_MAG  = 8'b0000_0010,
    S_GCD  = 8'b0000_0100,
    S_READ = 8'b0000_1000,
    S_LOAD = 8'b0001_0000,
    S_DIV  = 8'b0010_0000,
    S_NEG  = 8'b0100_0000,
    S_OUT  = 8'b1000_0000
  } state_t;

endpackage

// File: src/vgn_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vgn_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/vgn_subtractor.sv
// ----------------------------------------------------------------------------
// Shared subtractor
// Unsigned subtract with borrow out, used for negation, gcd steps and division.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vgn_subtractor #(
  parameter int WIDTH = 32
) (
  input  logic [WIDTH-1:0] a,
  input  logic [WIDTH-1:0] b,
  output logic [WIDTH-1:0] diff,
  output logic             borrow
);

  // The extra top bit of the difference is the borrow, set when a < b.
  assign {borrow, diff} = {1'b0, a} - {1'b0, b};

endmodule

// File: src/vector_gcd_normalize.sv
// ----------------------------------------------------------------------------
// Vector gcd normalize
// Buffers a vector of signed elements, keeps a running gcd of their
// magnitudes and emits the vector divided exactly by that gcd.
//
//   Channel  Handshake                    Payload
//   -------  ---------------------------  ---------------------------
//   element  element_valid/element_stall  element
//   result   result_valid/result_stall    value, simplified, last
//
// One subtractor serves every arithmetic step under a small sequencer.
// Each element is taken, turned into a magnitude and folded into the running
// gcd by one binary gcd step per cycle. The last element then starts the emit:
// each result is read from the store and, when the gcd is above one, divided
// by restoring division and negated again if negative, else passed on as is.
// Reset clears the sequencer, index, running gcd and result valid; there is
// no clearing pass. A stalled result holds the block until it is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vector_gcd_normalize #(
  parameter int VECTOR_LENGTH = 16,
  parameter int ELEMENT_WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            element_valid,
  output logic                            element_stall,
  input  logic signed [ELEMENT_WIDTH-1:0] element,
  output logic                            result_valid,
  input  logic                            result_stall,
  output logic signed [ELEMENT_WIDTH-1:0] value,
  output logic                            simplified,
  output logic                            last
);

  import vgn_pkg::*;

  localparam int W  = ELEMENT_WIDTH;
  localparam int IW = $clog2(VECTOR_LENGTH);
  localparam int KW = $clog2(ELEMENT_WIDTH);
  localparam logic [IW-1:0] LAST_IDX = IW'(VECTOR_LENGTH - 1);
  localparam logic [KW-1:0] LAST_BIT = KW'(ELEMENT_WIDTH - 1);

  state_t         state;
  logic [IW-1:0]  idx;
  logic [W-1:0]   gcd;
  logic           simp;
  logic [W-1:0]   ga;
  logic [W-1:0]   gb;
  logic [KW-1:0]  gk;
  logic           dneg;
  logic [W-1:0]   q;
  logic [W-1:0]   rem;
  logic [KW-1:0]  bitcnt;

  logic           ram_we;
  logic           ram_re;
  logic [W-1:0]   rdata;
  logic [W-1:0]   sub_a;
  logic [W-1:0]   sub_b;
  logic [W-1:0]   diff;
  logic           borrow;
  logic [W-1:0]   shifted;
  logic [W-1:0]   gres;
  logic [W-1:0]   q_next;

  // Intake is open only while the sequencer waits for an element.
  assign element_stall = (state != S_IDLE);
  assign ram_we        = (state == S_IDLE) && element_valid;
  assign ram_re        = (state == S_READ);

  vgn_ram #(
    .WIDTH(W),
    .DEPTH(VECTOR_LENGTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(idx),
    .wdata($unsigned(element)),
    .re   (ram_re),
    .raddr(idx),
    .rdata(rdata)
  );

  // Partial remainder shifted left with the next dividend bit brought in.
  assign shifted = {rem[W-2:0], q[W-1]};
  assign q_next  = {q[W-2:0], ~borrow};

  // Finished gcd: the nonzero operand restored by the common power of two.
  assign gres = (gb == '0) ? (ga << gk) : (gb << gk);

  // Operand selection for the shared subtractor.
  always_comb begin
    unique case (state)
      S_MAG: begin
        sub_a = '0;
        sub_b = gb;
      end
      S_GCD: begin
        sub_a = ga;
        sub_b = gb;
      end
      S_LOAD: begin
        sub_a = '0;
        sub_b = rdata;
      end
      S_DIV: begin
        sub_a = shifted;
        sub_b = gcd;
      end
      S_NEG: begin
        sub_a = '0;
        sub_b = q;
      end
      default: begin
        sub_a = '0;
        sub_b = '0;
      end
    endcase
  end

  vgn_subtractor #(
    .WIDTH(W)
  ) u_sub (
    .a     (sub_a),
    .b     (sub_b),
    .diff  (diff),
    .borrow(borrow)
  );

  // Sequencer and datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      idx          <= '0;
      gcd          <= '0;
      result_valid <= 1'b0;
    end else begin
      unique case (state)
        // Take an element; it is written to the store at the same edge.
        S_IDLE: begin
          if (element_valid) begin
            gb    <= $unsigned(element);
            state <= S_MAG;
          end
        end

        // Magnitude of the new element, gcd operands set up.
        S_MAG: begin
          if (gb[W-1]) begin
            gb <= diff;
          end
          ga    <= gcd;
          gk    <= '0;
          state <= S_GCD;
        end

        // One binary gcd step per cycle.
        S_GCD: begin
          priority if (ga == '0 || gb == '0) begin
            gcd <= gres;
            if (idx == LAST_IDX) begin
              simp  <= (gres > W'(1));
              idx   <= '0;
              state <= S_READ;
            end else begin
              idx   <= idx + 1'b1;
              state <= S_IDLE;
            end
          end else if (!ga[0] && !gb[0]) begin
            ga <= ga >> 1;
            gb <= gb >> 1;
            gk <= gk + 1'b1;
          end else if (!ga[0]) begin
            ga <= ga >> 1;
          end else if (!gb[0]) begin
            gb <= gb >> 1;
          end else if (borrow) begin
            ga <= gb;
            gb <= ga;
          end else begin
            ga <= diff;
          end
        end

        // Store read is in flight.
        S_READ: begin
          state <= S_LOAD;
        end

        // Stored element arrives: divide its magnitude or pass it on.
        S_LOAD: begin
          dneg <= rdata[W-1];
          if (simp) begin
            q      <= rdata[W-1] ? diff : rdata;
            rem    <= '0;
            bitcnt <= '0;
            state  <= S_DIV;
          end else begin
            value        <= $signed(rdata);
            simplified   <= 1'b0;
            last         <= (idx == LAST_IDX);
            result_valid <= 1'b1;
            state        <= S_OUT;
          end
        end

        // Restoring division, one quotient bit per cycle.
        S_DIV: begin
          rem    <= borrow ? shifted : diff;
          q      <= q_next;
          bitcnt <= bitcnt + 1'b1;
          if (bitcnt == LAST_BIT) begin
            if (dneg) begin
              state <= S_NEG;
            end else begin
              value        <= $signed(q_next);
              simplified   <= 1'b1;
              last         <= (idx == LAST_IDX);
              result_valid <= 1'b1;
              state        <= S_OUT;
            end
          end
        end

        // Restore the sign of a negative element.
        S_NEG: begin
          value        <= $signed(diff);
          simplified   <= 1'b1;
          last         <= (idx == LAST_IDX);
          result_valid <= 1'b1;
          state        <= S_OUT;
        end

        // Hold the result until it is taken.
        S_OUT: begin
          if (!result_stall) begin
            result_valid <= 1'b0;
            if (last) begin
              idx   <= '0;
              gcd   <= '0;
              state <= S_IDLE;
            end else begin
              idx   <= idx + 1'b1;
              state <= S_READ;
            end
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: src/vgn_checker.sv
// ----------------------------------------------------------------------------
// Vector gcd normalize checker
// Port-level assertions on intake, emit and reset behavior.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module vgn_checker #(
  parameter int ELEMENT_WIDTH = 32
) (
  input logic                            clk,
  input logic                            rst,
  input logic                            element_valid,
  input logic                            element_stall,
  input logic                            result_valid,
  input logic                            result_stall,
  input logic signed [ELEMENT_WIDTH-1:0] value,
  input logic                            last
);

  // Intake stays closed while a result is on offer.
  `ASSERT_IMPL(a_out_blocks_in, clk, rst, result_valid, element_stall, "intake open during emit")

  // Every accepted element keeps the block busy for at least the next cycle.
  `ASSERT_NEXT(a_in_busy, clk, rst, element_valid && !element_stall, element_stall, "no busy after item")

  // The final result of a vector reopens intake right away.
  `ASSERT_NEXT(a_last_reopens, clk, rst, result_valid && !result_stall && last, !element_stall && !result_valid, "intake not reopened")

  // A stalled result holds its value.
  `ASSERT_NEXT(a_out_hold, clk, rst, result_valid && result_stall, result_valid && $stable(value), "stalled result changed")

  // Reset withdraws any result.
  `ASSERT_NEXT_ALWAYS(a_reset_clear, clk, rst, !result_valid, "result valid after reset")

endmodule

bind vector_gcd_normalize vgn_checker #(
  .ELEMENT_WIDTH(ELEMENT_WIDTH)
) u_vgn_checker (
  .clk          (clk),
  .rst          (rst),
  .element_valid(element_valid),
  .element_stall(element_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .value        (value),
  .last         (last)
);
